/* src/trsq_pkg.sv */
// ----------------------------------------------------------------------------
// trsq_pkg: shared types and constants for the timed release sorted queue
// Field widths, request and result codes, and the per-cell control struct.
// ----------------------------------------------------------------------------
package trsq_pkg;

    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int ELAP_W = 16;
    localparam int KIND_W = 2;

    localparam int MAX_OUT = 32;
    localparam int CNT_W   = $clog2(MAX_OUT);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic ins_en;
        logic rel_en;
    } t_cell_ctl;

endpackage

/* src/trsq_req_if.sv */
// ----------------------------------------------------------------------------
// trsq_req_if: request channel
// Valid/ready channel carrying insert and tick requests.
// ----------------------------------------------------------------------------
interface trsq_req_if;
    import trsq_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [TIME_W-1:0] event_time;
    logic [TAG_W-1:0]  entry_tag;
    logic [ELAP_W-1:0] elapsed;

    modport source (output valid, output req_type, output event_time,
                    output entry_tag, output elapsed, input ready);
    modport sink   (input valid, input req_type, input event_time,
                    input entry_tag, input elapsed, output ready);
endinterface

/* src/trsq_res_if.sv */
// ----------------------------------------------------------------------------
// trsq_res_if: result channel
// Valid/ready channel carrying acknowledges and released entries.
// ----------------------------------------------------------------------------
interface trsq_res_if;
    import trsq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic              status;
    logic [TAG_W-1:0]  released_tag;
    logic [TIME_W-1:0] released_time;
    logic              last;

    modport source (output valid, output result_kind, output status,
                    output released_tag, output released_time, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input status,
                    input released_tag, input released_time, input last,
                    output ready);
endinterface

/* src/timed_release_sorted_queue.sv */
// ----------------------------------------------------------------------------
// timed_release_sorted_queue: sorted queue of timed entries
// Insert: the acknowledge is registered from the insert state; the next request
// is accepted once the queue is back in idle. Tick: results are registered from
// the tick state, one released entry per cycle while the output is not held by
// back-pressure; a tick that releases nothing gives one empty result.
// Synchronous active-low reset empties the queue and clears current time.
// ----------------------------------------------------------------------------
module timed_release_sorted_queue #(
    parameter int DEPTH     = 32,
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trsq_req_if.sink   i_req,
    trsq_res_if.source o_res
);
    import trsq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INS  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] n_now;
    logic [TIME_BITS-1:0] r_end;
    logic [TIME_BITS-1:0] n_end;
    logic [TIME_BITS-1:0] r_ins_time;
    logic [TAG_BITS-1:0]  r_ins_tag;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [KIND_W-1:0]    r_out_kind;
    logic [KIND_W-1:0]    n_out_kind;
    logic                 r_out_status;
    logic                 n_out_status;
    logic [TAG_W-1:0]     r_out_tag;
    logic [TAG_W-1:0]     n_out_tag;
    logic [TIME_W-1:0]    r_out_time;
    logic [TIME_W-1:0]    n_out_time;
    logic                 r_out_last;
    logic                 n_out_last;

    t_cell_ctl            w_ctl;
    logic                 w_out_free;
    logic                 w_full;
    logic [TIME_BITS:0]   w_sum;

    logic [DEPTH-1:0]     w_valid;
    logic [TIME_BITS-1:0] w_time [DEPTH];
    logic [TAG_BITS-1:0]  w_tag  [DEPTH];
    logic [DEPTH-1:0]     w_ins;
    logic [DEPTH-1:0]     w_due;
    logic [DEPTH-1:0]     w_win;

    logic [DEPTH-1:0]     w_lv;
    logic [TIME_BITS-1:0] w_lt   [DEPTH];
    logic [TAG_BITS-1:0]  w_ltag [DEPTH];
    logic [DEPTH-1:0]     w_lins;
    logic [DEPTH-1:0]     w_ldue;
    logic [DEPTH-1:0]     w_rv;
    logic [TIME_BITS-1:0] w_rt   [DEPTH];
    logic [TAG_BITS-1:0]  w_rtag [DEPTH];
    logic [DEPTH-1:0]     w_rwin;

    logic [DEPTH-1:0]     w_sel;
    logic                 w_rel_ok;
    logic                 w_next_ok;
    logic [TIME_BITS-1:0] w_sel_time;
    logic [TAG_BITS-1:0]  w_sel_tag;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                w_lv[i]   = 1'b0;
                w_lt[i]   = '0;
                w_ltag[i] = '0;
                w_lins[i] = 1'b0;
                w_ldue[i] = 1'b0;
            end else begin
                w_lv[i]   = w_valid[i-1];
                w_lt[i]   = w_time[i-1];
                w_ltag[i] = w_tag[i-1];
                w_lins[i] = w_ins[i-1];
                w_ldue[i] = w_due[i-1];
            end
            if (i == DEPTH - 1) begin
                w_rv[i]   = 1'b0;
                w_rt[i]   = '0;
                w_rtag[i] = '0;
                w_rwin[i] = 1'b0;
            end else begin
                w_rv[i]   = w_valid[i+1];
                w_rt[i]   = w_time[i+1];
                w_rtag[i] = w_tag[i+1];
                w_rwin[i] = w_win[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        trsq_cell #(
            .TIME_BITS (TIME_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_ins_time    (r_ins_time),
            .i_ins_tag     (r_ins_tag),
            .i_now         (r_now),
            .i_end         (r_end),
            .i_left_valid  (w_lv[g]),
            .i_left_time   (w_lt[g]),
            .i_left_tag    (w_ltag[g]),
            .i_left_ins    (w_lins[g]),
            .i_right_valid (w_rv[g]),
            .i_right_time  (w_rt[g]),
            .i_right_tag   (w_rtag[g]),
            .o_valid       (w_valid[g]),
            .o_time        (w_time[g]),
            .o_tag         (w_tag[g]),
            .o_ins         (w_ins[g]),
            .o_due         (w_due[g]),
            .o_in_window   (w_win[g])
        );
    end

    always_comb begin
        w_rel_ok   = 1'b0;
        w_next_ok  = 1'b0;
        w_sel_time = '0;
        w_sel_tag  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel[i]   = w_due[i] && !w_ldue[i];
            w_rel_ok   = w_rel_ok  | (w_sel[i] & w_win[i]);
            w_next_ok  = w_next_ok | (w_sel[i] & w_rwin[i]);
            w_sel_time = w_sel_time | ({TIME_BITS{w_sel[i]}} & w_time[i]);
            w_sel_tag  = w_sel_tag  | ({TAG_BITS{w_sel[i]}} & w_tag[i]);
        end
    end

    assign w_full     = w_valid[DEPTH-1];
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_sum      = {1'b0, r_now} + (TIME_BITS + 1)'(i_req.elapsed);
    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_end        = r_end;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;
        w_ctl        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_INSERT) begin
                        n_state = ST_INS;
                    end else begin
                        n_state = ST_TICK;
                        n_cnt   = '0;
                        n_end   = w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0];
                    end
                end
            end
            ST_INS: begin
                if (w_out_free) begin
                    w_ctl.ins_en = !w_full;
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_ACK;
                    n_out_status = w_full ? STATUS_FULL : STATUS_OK;
                    n_out_tag    = '0;
                    n_out_time   = '0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STATUS_OK;
                    if (w_rel_ok) begin
                        w_ctl.rel_en = 1'b1;
                        n_out_kind   = KIND_REL;
                        n_out_tag    = TAG_W'(w_sel_tag);
                        n_out_time   = TIME_W'(w_sel_time);
                        n_out_last   = !w_next_ok || (r_cnt == CNT_W'(MAX_OUT - 1));
                        n_cnt        = r_cnt + 1'b1;
                    end else begin
                        n_out_kind   = KIND_NONE;
                        n_out_tag    = '0;
                        n_out_time   = '0;
                        n_out_last   = 1'b1;
                    end
                    if (n_out_last) begin
                        n_now   = r_end;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_end        <= n_end;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_tag    <= n_out_tag;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
        if (i_req.valid && i_req.ready) begin
            r_ins_time <= TIME_BITS'(i_req.event_time);
            r_ins_tag  <= TAG_BITS'(i_req.entry_tag);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_out_kind;
    assign o_res.status        = r_out_status;
    assign o_res.released_tag  = r_out_tag;
    assign o_res.released_time = r_out_time;
    assign o_res.last          = r_out_last;

`ifndef SYNTHESIS
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("occupied cells are not contiguous");

    a_insert_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_type == REQ_INSERT)
        |=> r_state == ST_INS)
        else $error("accepted insert did not enter insert state");

    a_empty_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK && w_out_free && !w_rel_ok) |-> r_cnt == '0)
        else $error("empty tick result after a release");
`endif

endmodule

/* src/trsq_cell.sv */
// ----------------------------------------------------------------------------
// trsq_cell: one slot of the sorted chain
// Holds one entry, compares it locally and takes data from a neighbour
// on insert (shift right) or release (shift left).
// ----------------------------------------------------------------------------
module trsq_cell #(
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  trsq_pkg::t_cell_ctl    i_ctl,
    input  logic [TIME_BITS-1:0]   i_ins_time,
    input  logic [TAG_BITS-1:0]    i_ins_tag,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic [TIME_BITS-1:0]   i_end,
    input  logic                   i_left_valid,
    input  logic [TIME_BITS-1:0]   i_left_time,
    input  logic [TAG_BITS-1:0]    i_left_tag,
    input  logic                   i_left_ins,
    input  logic                   i_right_valid,
    input  logic [TIME_BITS-1:0]   i_right_time,
    input  logic [TAG_BITS-1:0]    i_right_tag,
    output logic                   o_valid,
    output logic [TIME_BITS-1:0]   o_time,
    output logic [TAG_BITS-1:0]    o_tag,
    output logic                   o_ins,
    output logic                   o_due,
    output logic                   o_in_window
);
    import trsq_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_time;
    logic [TAG_BITS-1:0]  r_tag;
    logic [TAG_BITS-1:0]  n_tag;

    assign o_ins       = !r_valid || (r_time >= i_ins_time);
    assign o_due       = r_valid && (r_time >= i_now);
    assign o_in_window = r_valid && (r_time < i_end);

    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_tag   = r_tag;
        if (i_ctl.ins_en && o_ins) begin
            if (i_left_ins) begin
                n_valid = i_left_valid;
                n_time  = i_left_time;
                n_tag   = i_left_tag;
            end else begin
                n_valid = 1'b1;
                n_time  = i_ins_time;
                n_tag   = i_ins_tag;
            end
        end else if (i_ctl.rel_en && o_due) begin
            n_valid = i_right_valid;
            n_time  = i_right_time;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_time <= n_time;
        r_tag  <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_time  = r_time;
    assign o_tag   = r_tag;

endmodule

/* sim/timed_release_sorted_queue_tb.sv */
// ----------------------------------------------------------------------------
// timed_release_sorted_queue_tb: testbench for the timed release sorted queue
// Drives insert and tick requests through the request channel and checks
// every acknowledge and released entry against an in-bench model of the
// sorted queue and its running time. Covers ordering of equal times, a full
// queue, stale entries, output back-pressure, random traffic under three
// idling mixes, and entries at the top of the time range.
// ----------------------------------------------------------------------------
module timed_release_sorted_queue_tb;
    import trsq_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              status;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] rel_time;
        logic              last;
    } t_release_rec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    trsq_req_if req_ch ();
    trsq_res_if res_ch ();

    timed_release_sorted_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .TIME_BITS (TIME_W),
        .TAG_BITS  (TAG_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // Queue model
    logic [TIME_W-1:0] slot_due [QUEUE_DEPTH];
    logic [TAG_W-1:0]  slot_id  [QUEUE_DEPTH];
    int                fill_count;
    logic [TIME_W-1:0] clock_now;

    t_release_rec expected_results [$];
    t_release_rec seen_result;
    t_release_rec want_result;
    int           fail_count;
    int           req_idle_pct;
    int           res_idle_pct;
    logic         res_hold = 1'b0;
    event         res_hold_start;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void add_expected(input t_release_rec rec);
        expected_results = {expected_results, rec};
    endfunction

    function automatic void model_insert(input logic [TIME_W-1:0] due,
                                         input logic [TAG_W-1:0] id);
        int pos;
        if (fill_count >= QUEUE_DEPTH) begin
            add_expected(t_release_rec'{KIND_ACK, STATUS_FULL, '0, '0, 1'b1});
            return;
        end
        pos = 0;
        while (pos < fill_count && slot_due[pos] < due) pos++;
        for (int i = fill_count; i > pos; i--) begin
            slot_due[i] = slot_due[i-1];
            slot_id[i]  = slot_id[i-1];
        end
        slot_due[pos] = due;
        slot_id[pos]  = id;
        fill_count++;
        add_expected(t_release_rec'{KIND_ACK, STATUS_OK, '0, '0, 1'b1});
    endfunction

    function automatic void model_tick(input logic [ELAP_W-1:0] el);
        logic [TIME_W:0]   wide_end;
        logic [TIME_W-1:0] win_end;
        int                first;
        int                stop;
        int                n;
        wide_end = {1'b0, clock_now} + (TIME_W + 1)'(el);
        win_end  = wide_end[TIME_W] ? '1 : wide_end[TIME_W-1:0];
        first = 0;
        while (first < fill_count && slot_due[first] < clock_now) first++;
        stop = first;
        while (stop < fill_count && slot_due[stop] < win_end && (stop - first) < MAX_OUT)
            stop++;
        n = stop - first;
        for (int i = first; i < stop; i++)
            add_expected(t_release_rec'{KIND_REL, STATUS_OK, slot_id[i], slot_due[i],
                                        (i + 1 == stop)});
        if (n > 0) begin
            for (int i = stop; i < fill_count; i++) begin
                slot_due[i-n] = slot_due[i];
                slot_id[i-n]  = slot_id[i];
            end
            fill_count -= n;
        end else begin
            add_expected(t_release_rec'{KIND_NONE, STATUS_OK, '0, '0, 1'b1});
        end
        clock_now = win_end;
    endfunction

    // Offer one request; returns in the time step of its transaction.
    task automatic offer_request(input logic kind, input logic [TIME_W-1:0] due,
                                 input logic [TAG_W-1:0] id, input logic [ELAP_W-1:0] el);
        if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < req_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.event_time <= due;
        req_ch.entry_tag  <= id;
        req_ch.elapsed    <= el;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        if (kind == REQ_INSERT)
            model_insert(due, id);
        else
            model_tick(el);
    endtask

    task automatic insert_entry(input logic [TIME_W-1:0] due, input logic [TAG_W-1:0] id);
        offer_request(REQ_INSERT, due, id, ELAP_W'($urandom));
    endtask

    task automatic advance_time(input logic [ELAP_W-1:0] el);
        offer_request(REQ_TICK, $urandom, TAG_W'($urandom), el);
    endtask

    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int req_pct, input int res_pct);
        req_idle_pct = req_pct;
        res_idle_pct = res_pct;
    endtask

    task automatic test_empty_ticks_and_ordering();
        advance_time(16'd0);
        advance_time(16'd100);
        insert_entry(32'd100, 16'h0000);
        insert_entry(32'd150, 16'hFFFF);
        insert_entry(32'd150, 16'h1234);
        insert_entry(32'd120, 16'hA5A5);
        advance_time(16'd30);
        advance_time(16'd1);
        advance_time(16'hFFFF);
        pause_until_drained();
    endtask

    task automatic test_full_queue();
        while (fill_count < QUEUE_DEPTH)
            insert_entry(clock_now + $urandom_range(0, 60000), TAG_W'($urandom));
        insert_entry(clock_now + 32'd5, TAG_W'($urandom));
        advance_time(16'hFFFF);
        pause_until_drained();
    endtask

    task automatic test_stale_entries();
        insert_entry(clock_now - 32'd5, TAG_W'($urandom));
        insert_entry(32'd0, TAG_W'($urandom));
        insert_entry(clock_now, TAG_W'($urandom));
        insert_entry(clock_now + 32'd10, TAG_W'($urandom));
        insert_entry(32'hFFFF_FFFF, TAG_W'($urandom));
        advance_time(16'd10);
        advance_time(16'd1);
        pause_until_drained();
    endtask

    task automatic test_output_backpressure();
        -> res_hold_start;
        repeat (10) insert_entry(clock_now + $urandom_range(0, 2000), TAG_W'($urandom));
        advance_time(16'd2500);
        pause_until_drained();
    endtask

    task automatic test_random_traffic(input int count, input int req_pct, input int res_pct);
        int roll;
        logic [ELAP_W-1:0] el;
        set_idling(req_pct, res_pct);
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                insert_entry(clock_now + $urandom_range(0, 3000), TAG_W'($urandom));
            end else if (roll < 62) begin
                insert_entry($urandom, TAG_W'($urandom));
            end else if (roll < 67) begin
                insert_entry(clock_now - $urandom_range(0, 1000), TAG_W'($urandom));
            end else begin
                case ($urandom_range(9))
                    0:       el = '0;
                    1:       el = '1;
                    2:       el = ELAP_W'($urandom);
                    default: el = ELAP_W'($urandom_range(1, 800));
                endcase
                advance_time(el);
            end
        end
        pause_until_drained();
    endtask

    task automatic test_far_future_entries();
        insert_entry(32'hFFFF_FFFE, TAG_W'($urandom));
        insert_entry(32'hFFFF_FFFF, TAG_W'($urandom));
        advance_time(16'hFFFF);
        advance_time(16'd0);
        advance_time(16'd7);
        pause_until_drained();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            seen_result = '{res_ch.result_kind, res_ch.status, res_ch.released_tag,
                            res_ch.released_time, res_ch.last};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction kind=%0d status=%0d tag=%h time=%h last=%0d",
                         $time, seen_result.kind, seen_result.status, seen_result.tag,
                         seen_result.rel_time, seen_result.last);
                fail_count++;
            end else begin
                want_result = expected_results.pop_front();
                if (seen_result !== want_result) begin
                    $display({"%0t: mismatch expected kind=%0d status=%0d tag=%h time=%h ",
                              "last=%0d, actual kind=%0d status=%0d tag=%h time=%h last=%0d"},
                             $time, want_result.kind, want_result.status, want_result.tag,
                             want_result.rel_time, want_result.last, seen_result.kind,
                             seen_result.status, seen_result.tag, seen_result.rel_time,
                             seen_result.last);
                    fail_count++;
                end
            end
        end
        if (res_hold)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= res_idle_pct);
    end

    always begin
        @(res_hold_start);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold <= 1'b0;
    end

    initial begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        fail_count   = 0;
        fill_count   = 0;
        clock_now    = '0;
        req_idle_pct = 0;
        res_idle_pct = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_INSERT;
        req_ch.event_time <= '0;
        req_ch.entry_tag  <= '0;
        req_ch.elapsed    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(24, 63);
        test_empty_ticks_and_ordering();
        test_full_queue();
        test_stale_entries();
        test_random_traffic(20, 24, 63);
        test_random_traffic(20, 63, 24);
        test_random_traffic(20, 0, 0);
        test_output_backpressure();
        test_far_future_entries();

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
